@@ rtl/core/fsk_envelope_uart_deframer_unit_defines.svh @@
// Assertion macros for the FSK envelope UART deframer.
`ifndef FSK_ENVELOPE_UART_DEFRAMER_UNIT_DEFINES_SVH
`define FSK_ENVELOPE_UART_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSKUD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSKUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fskud_pkg.sv @@
// Shared constants, codes and types of the FSK envelope UART deframer.
package fskud_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DATA_BITS    = 8;

    localparam int DECAY_W  = 16;
    localparam int MIN_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int HALF_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 2;
    localparam int TIMER_W  = HALF_W + 2;
    localparam int BITCNT_W = $clog2(DATA_BITS + 1);
    localparam int SUM_W    = SAMPLE_WIDTH + 1;
    localparam int SHARE_W  = SUM_W + FRAC_W;

    localparam logic [SAMPLE_WIDTH-1:0] FULL_SCALE = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1);

    // register indexes
    localparam logic [CFG_AW-1:0] REG_DECAY   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_AMP = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SCHMITT = 2'd2;
    localparam logic [CFG_AW-1:0] REG_HALF    = 2'd3;

    localparam logic [DECAY_W-1:0] DECAY_RST   = 16'd61871;
    localparam logic [MIN_W-1:0]   MIN_AMP_RST = 16'd3277;
    localparam logic [FRAC_W-1:0]  SCHMITT_RST = 8'd179;
    localparam logic [HALF_W-1:0]  HALF_RST    = 16'd20;

    // line bit codes
    localparam logic [1:0] BIT_ZERO    = 2'd0;
    localparam logic [1:0] BIT_ONE     = 2'd1;
    localparam logic [1:0] BIT_INVALID = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_START    = 3'd1;
    localparam logic [2:0] EV_DATA0    = 3'd2;
    localparam logic [2:0] EV_DATA1    = 3'd3;
    localparam logic [2:0] EV_DATA_ERR = 3'd4;
    localparam logic [2:0] EV_STOP     = 3'd5;
    localparam logic [2:0] EV_STOP_ERR = 3'd6;

    localparam int IN_BITS  = 2 * SAMPLE_WIDTH;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * SAMPLE_WIDTH + 2 + 3 + 1 + DATA_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] upper_level;
        logic [SAMPLE_WIDTH-1:0] lower_level;
        logic [1:0]              bit_state;
        logic [2:0]              event_res;
        logic                    byte_valid;
        logic [DATA_BITS-1:0]    data_byte;
    } result_t;

    typedef struct packed {
        logic [MIN_W-1:0]  min_amplitude;
        logic [FRAC_W-1:0] schmitt_fraction;
    } slicer_cfg_t;

endpackage

@@ rtl/core/fskud_envelope.sv @@
// Rectifier and peak envelope of both tones; the level registers are the stage-one payload.
module fskud_envelope
    import fskud_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] upper_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] lower_sample,
    input  logic [DECAY_W-1:0]             decay_factor,
    output logic [SAMPLE_WIDTH-1:0]        upper_level,
    output logic [SAMPLE_WIDTH-1:0]        lower_level
);

    logic [SAMPLE_WIDTH-1:0] upper_reg, upper_next;
    logic [SAMPLE_WIDTH-1:0] lower_reg, lower_next;
    logic [SAMPLE_WIDTH-1:0] upper_rect, lower_rect;
    logic [SAMPLE_WIDTH+DECAY_W-1:0] upper_prod, lower_prod;
    logic [SAMPLE_WIDTH-1:0] upper_dec, lower_dec;

    // |s|, with +max also mapped to full scale
    function automatic logic [SAMPLE_WIDTH-1:0] rectify(input logic [SAMPLE_WIDTH-1:0] s);
        logic [SAMPLE_WIDTH:0] mag;
        mag = s[SAMPLE_WIDTH-1] ? ((SAMPLE_WIDTH+1)'(1) << SAMPLE_WIDTH) - {1'b0, s}
                                : {1'b0, s};
        if (mag >= {1'b0, FULL_SCALE} - (SAMPLE_WIDTH+1)'(1))
        begin
            mag = {1'b0, FULL_SCALE};
        end
        return mag[SAMPLE_WIDTH-1:0];
    endfunction

    always_comb
    begin
        upper_rect = rectify(upper_sample);
        lower_rect = rectify(lower_sample);
        upper_prod = upper_reg * decay_factor;
        lower_prod = lower_reg * decay_factor;
        upper_dec  = upper_prod[SAMPLE_WIDTH+DECAY_W-1:DECAY_W];
        lower_dec  = lower_prod[SAMPLE_WIDTH+DECAY_W-1:DECAY_W];
        upper_next = (upper_rect > upper_dec) ? upper_rect : upper_dec;
        lower_next = (lower_rect > lower_dec) ? lower_rect : lower_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else if (load)
        begin
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

    assign upper_level = upper_reg;
    assign lower_level = lower_reg;

endmodule

@@ rtl/core/fskud_slicer.sv @@
// Amplitude check and Schmitt decision of the line bit.
module fskud_slicer
    import fskud_pkg::*;
(
    input  logic [SAMPLE_WIDTH-1:0] upper_level,
    input  logic [SAMPLE_WIDTH-1:0] lower_level,
    input  slicer_cfg_t             cfg,
    input  logic [1:0]              last_bit,
    output logic [1:0]              bit_state
);

    logic [SUM_W-1:0]   sum;
    logic [SHARE_W-1:0] share;
    logic [SHARE_W-1:0] upper_scaled, lower_scaled;

    always_comb
    begin
        sum          = {1'b0, upper_level} + {1'b0, lower_level};
        share        = SHARE_W'(sum) * SHARE_W'(cfg.schmitt_fraction);
        upper_scaled = SHARE_W'(upper_level) << FRAC_W;
        lower_scaled = SHARE_W'(lower_level) << FRAC_W;
        bit_state    = last_bit;
        if (SHARE_W'(sum) < SHARE_W'(cfg.min_amplitude))
        begin
            bit_state = BIT_INVALID;
        end
        else if (upper_scaled > share && (last_bit == BIT_ZERO || last_bit == BIT_INVALID))
        begin
            bit_state = BIT_ONE;
        end
        else if (lower_scaled > share && (last_bit == BIT_ONE || last_bit == BIT_INVALID))
        begin
            bit_state = BIT_ZERO;
        end
    end

endmodule

@@ rtl/core/fskud_deframer.sv @@
// UART frame timer, shift register and result register.
module fskud_deframer
    import fskud_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [SAMPLE_WIDTH-1:0] upper_level,
    input  logic [SAMPLE_WIDTH-1:0] lower_level,
    input  slicer_cfg_t             slicer_cfg,
    input  logic [HALF_W-1:0]       half_bit_samples,
    output result_t                 result
);

    logic [1:0]           last_bit_reg, bit_now;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic [BITCNT_W-1:0]  bits_reg, bits_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    result_t              res_reg, res_next;
    logic [TIMER_W-1:0]   half_ext;

    fskud_slicer u_slicer (
        .upper_level (upper_level),
        .lower_level (lower_level),
        .cfg         (slicer_cfg),
        .last_bit    (last_bit_reg),
        .bit_state   (bit_now)
    );

    assign half_ext = TIMER_W'(half_bit_samples);

    always_comb
    begin
        timer_next = timer_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        res_next.upper_level = upper_level;
        res_next.lower_level = lower_level;
        res_next.bit_state   = bit_now;
        res_next.event_res   = EV_NONE;
        res_next.byte_valid  = 1'b0;
        res_next.data_byte   = '0;
        if (timer_reg == '0)
        begin
            if (last_bit_reg != bit_now && bit_now == BIT_ZERO)
            begin
                timer_next = (half_ext << 1) + half_ext;
                bits_next  = BITCNT_W'(DATA_BITS);
                shift_next = '0;
                res_next.event_res = EV_START;
            end
        end
        else if (timer_reg == TIMER_W'(1))
        begin
            timer_next = '0;
            if (bits_reg == '0)
            begin
                if (bit_now == BIT_ONE)
                begin
                    res_next.byte_valid = 1'b1;
                    res_next.data_byte  = ~shift_reg;
                    res_next.event_res  = EV_STOP;
                end
                else
                begin
                    res_next.event_res = EV_STOP_ERR;
                end
                shift_next = '0;
            end
            else
            begin
                timer_next = half_ext << 1;
                bits_next  = bits_reg - BITCNT_W'(1);
                shift_next = {bit_now == BIT_ONE, shift_reg[DATA_BITS-1:1]};
                if (bit_now == BIT_ONE)
                begin
                    res_next.event_res = EV_DATA1;
                end
                else if (bit_now == BIT_ZERO)
                begin
                    res_next.event_res = EV_DATA0;
                end
                else
                begin
                    timer_next = '0;  // invalid data bit aborts the frame
                    res_next.event_res = EV_DATA_ERR;
                end
            end
        end
        else
        begin
            timer_next = timer_reg - TIMER_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_bit_reg <= BIT_INVALID;
            timer_reg    <= '0;
            bits_reg     <= '0;
            shift_reg    <= '0;
        end
        else if (load)
        begin
            last_bit_reg <= bit_now;
            timer_reg    <= timer_next;
            bits_reg     <= bits_next;
            shift_reg    <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

@@ rtl/core/fsk_envelope_uart_deframer_unit.sv @@
// Top level of the FSK envelope UART deframer: config registers, pipeline control.
// A beat accepted into the envelope level registers moves on to the result register.
// One beat per cycle unless the master side stalls; stage one is the envelope level
//   registers, stage two the Schmitt decision and frame logic feeding the result register.
// Either stage fills while the stage after it is stalled, so a waiting result
//   does not stop the slave side as long as stage one is free.
// Reset (rst_n low, asynchronous): pipeline empty, levels zero, line bit invalid,
//   deframer idle, config registers at their defaults.
`include "fsk_envelope_uart_deframer_unit_defines.svh"
module fsk_envelope_uart_deframer_unit
    import fskud_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // config write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // upper_sample, lower_sample
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // upper_level, lower_level, bit_state,
                                         // event_res, byte_valid, data_byte, zero pad
);

    logic [DECAY_W-1:0] decay_reg;
    logic [MIN_W-1:0]   min_amp_reg;
    logic [FRAC_W-1:0]  schmitt_reg;
    logic [HALF_W-1:0]  half_reg;

    logic v1_reg, vo_reg;
    logic load1, load2;

    logic [SAMPLE_WIDTH-1:0] upper_level, lower_level;
    slicer_cfg_t             slicer_cfg;
    result_t                 result;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= DECAY_RST;
            min_amp_reg <= MIN_AMP_RST;
            schmitt_reg <= SCHMITT_RST;
            half_reg    <= HALF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DECAY:   decay_reg   <= cfg_wdata[DECAY_W-1:0];
                REG_MIN_AMP: min_amp_reg <= cfg_wdata[MIN_W-1:0];
                REG_SCHMITT: schmitt_reg <= cfg_wdata[FRAC_W-1:0];
                REG_HALF:    half_reg    <= cfg_wdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // elastic two-stage control: a stage loads when it is empty or draining
    assign load2    = v1_reg && (!vo_reg || m_tready);
    assign s_tready = !v1_reg || load2;
    assign load1    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v1_reg <= s_tvalid;
            end
            if (!vo_reg || m_tready)
            begin
                vo_reg <= v1_reg;
            end
        end
    end

    fskud_envelope u_envelope (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load1),
        .upper_sample (s_tdata[SAMPLE_WIDTH-1:0]),
        .lower_sample (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .decay_factor (decay_reg),
        .upper_level  (upper_level),
        .lower_level  (lower_level)
    );

    assign slicer_cfg.min_amplitude    = min_amp_reg;
    assign slicer_cfg.schmitt_fraction = schmitt_reg;

    fskud_deframer u_deframer (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load2),
        .upper_level      (upper_level),
        .lower_level      (lower_level),
        .slicer_cfg       (slicer_cfg),
        .half_bit_samples (half_reg),
        .result           (result)
    );

    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_W'({result.data_byte, result.byte_valid, result.event_res,
                              result.bit_state, result.lower_level, result.upper_level});

    `FSKUD_ASSERT_NOW(a_byte_only_on_stop, clk, rst_n, m_tvalid && result.byte_valid,
        result.event_res == EV_STOP, "byte flagged without a stop event")
    `FSKUD_ASSERT_NOW(a_stall_means_full, clk, rst_n, !s_tready,
        v1_reg && vo_reg, "slave side stalled with a free stage")
    `FSKUD_ASSERT_NEXT(a_result_kept, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid, "pending result dropped")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the FSK envelope detector and UART deframer unit.
`timescale 1ns / 100ps

module tb;
    import fskud_pkg::*;

    // Result field offsets inside m_tdata, lowest field first.
    localparam int LO_AT = SAMPLE_WIDTH;
    localparam int BS_AT = 2 * SAMPLE_WIDTH;
    localparam int EV_AT = BS_AT + 2;
    localparam int BV_AT = EV_AT + 3;
    localparam int DB_AT = BV_AT + 1;

    // No beat on either side and no register write for this long means a hang.
    localparam int STALL_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // Sample pairs waiting to be sent, and line results predicted for accepted beats.
    logic [IN_W-1:0] sample_q[$];
    result_t         expected_q[$];

    int errors = 0;
    int queued_items = 0;
    int stall_cycles = 0;
    bit calm = 1'b0;   // set: neither side idles

    // Register copies used by the predictor.
    logic [DECAY_W-1:0] cfg_decay;
    logic [MIN_W-1:0]   cfg_min_amp;
    logic [FRAC_W-1:0]  cfg_schmitt;
    logic [HALF_W-1:0]  cfg_half;

    // Predictor state: both envelopes, the previous line bit and the deframer.
    logic [SAMPLE_WIDTH-1:0] up_env;
    logic [SAMPLE_WIDTH-1:0] lo_env;
    logic [1:0]              last_line;
    logic [TIMER_W-1:0]      frame_timer;
    logic [3:0]              bits_left;
    logic [DATA_BITS-1:0]    shreg;

    fsk_envelope_uart_deframer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Magnitude of a sample; the positive full-scale code also reads as 1.0.
    function automatic logic [SAMPLE_WIDTH-1:0] rectify(logic [SAMPLE_WIDTH-1:0] raw);
        logic [SAMPLE_WIDTH:0] mag;
        mag = raw[SAMPLE_WIDTH-1] ? ((SAMPLE_WIDTH+1)'(1) << SAMPLE_WIDTH) - {1'b0, raw}
                                  : {1'b0, raw};
        if (mag >= (SAMPLE_WIDTH+1)'(FULL_SCALE) - 1)
            mag = (SAMPLE_WIDTH+1)'(FULL_SCALE);
        return mag[SAMPLE_WIDTH-1:0];
    endfunction

    // Peak hold with floored decay.
    function automatic logic [SAMPLE_WIDTH-1:0] decay_env(logic [SAMPLE_WIDTH-1:0] lvl,
                                                          logic [SAMPLE_WIDTH-1:0] rect);
        logic [31:0] scaled;
        scaled = (32'(lvl) * 32'(cfg_decay)) >> 16;
        return (32'(rect) > scaled) ? rect : scaled[SAMPLE_WIDTH-1:0];
    endfunction

    // One sample pair through envelopes, slicer and deframer.
    function automatic result_t demod_step(logic [SAMPLE_WIDTH-1:0] up_raw,
                                           logic [SAMPLE_WIDTH-1:0] lo_raw);
        result_t     r;
        logic [31:0] level_sum;
        logic [31:0] share;
        logic [1:0]  line;
        r = '0;
        up_env = decay_env(up_env, rectify(up_raw));
        lo_env = decay_env(lo_env, rectify(lo_raw));
        level_sum = 32'(up_env) + 32'(lo_env);
        share = level_sum * 32'(cfg_schmitt);
        line = last_line;
        // Schmitt slicer: invalid below the minimum, else a tone must beat its share of the sum, otherwise hold
        if (level_sum < 32'(cfg_min_amp))
            line = BIT_INVALID;
        else if ((32'(up_env) << 8) > share && line != BIT_ONE)
            line = BIT_ONE;
        else if ((32'(lo_env) << 8) > share && line != BIT_ZERO)
            line = BIT_ZERO;

        if (frame_timer == 0)
        begin
            // start bit: falling edge to zero while idle
            if (last_line != line && line == BIT_ZERO)
            begin
                frame_timer = TIMER_W'(cfg_half) * TIMER_W'(3);
                bits_left = 4'(DATA_BITS);
                shreg = '0;
                r.event_res = EV_START;
            end
        end
        else if (frame_timer == 1)
        begin
            frame_timer = '0;
            if (bits_left == 0)
            begin
                if (line == BIT_ONE)
                begin
                    r.byte_valid = 1'b1;
                    r.data_byte = ~shreg;
                    r.event_res = EV_STOP;
                end
                else
                    r.event_res = EV_STOP_ERR;
                shreg = '0;
            end
            else
            begin
                frame_timer = TIMER_W'(cfg_half) * TIMER_W'(2);
                bits_left = bits_left - 4'd1;
                shreg = shreg >> 1;
                if (line == BIT_ONE)
                begin
                    shreg[DATA_BITS-1] = 1'b1;
                    r.event_res = EV_DATA1;
                end
                else if (line == BIT_ZERO)
                    r.event_res = EV_DATA0;
                else
                begin
                    // bad data bit drops the frame, partial byte stays
                    frame_timer = '0;
                    r.event_res = EV_DATA_ERR;
                end
            end
        end
        else
            frame_timer = frame_timer - 1'b1;
        last_line = line;

        r.upper_level = up_env;
        r.lower_level = lo_env;
        r.bit_state = line;
        return r;
    endfunction

    // Decay that drops a tone to a tenth over one bit of 2*h samples.
    function automatic logic [DECAY_W-1:0] decay_for(int h);
        real r;
        r = 65536.0 * (0.1 ** (1.0 / (2.0 * h)));
        return (r > 65535.0) ? 16'hFFFF : DECAY_W'($rtoi(r));
    endfunction

    // Sender: presents the head of sample_q, holds it until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(demod_step(s_tdata[SAMPLE_WIDTH-1:0],
                                                s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
                sample_q.delete(0);
            end
            if (sample_q.size() != 0 &&
                ((s_tvalid && !s_tready) || calm || $urandom_range(99) >= 34))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= sample_q[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, every result beat checked field by field.
    always @(posedge clk)
    begin : rx
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no sample pending: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[LO_AT-1:0] !== want.upper_level)
                    begin
                        $error("upper_level expected %0d got %0d",
                               want.upper_level, m_tdata[LO_AT-1:0]);
                        errors++;
                    end
                    if (m_tdata[BS_AT-1:LO_AT] !== want.lower_level)
                    begin
                        $error("lower_level expected %0d got %0d",
                               want.lower_level, m_tdata[BS_AT-1:LO_AT]);
                        errors++;
                    end
                    if (m_tdata[EV_AT-1:BS_AT] !== want.bit_state)
                    begin
                        $error("bit_state expected %0d got %0d",
                               want.bit_state, m_tdata[EV_AT-1:BS_AT]);
                        errors++;
                    end
                    if (m_tdata[BV_AT-1:EV_AT] !== want.event_res)
                    begin
                        $error("event_res expected %0d got %0d",
                               want.event_res, m_tdata[BV_AT-1:EV_AT]);
                        errors++;
                    end
                    if (m_tdata[BV_AT] !== want.byte_valid)
                    begin
                        $error("byte_valid expected %0d got %0d",
                               want.byte_valid, m_tdata[BV_AT]);
                        errors++;
                    end
                    if (m_tdata[DB_AT+DATA_BITS-1:DB_AT] !== want.data_byte)
                    begin
                        $error("data_byte expected %0h got %0h",
                               want.data_byte, m_tdata[DB_AT+DATA_BITS-1:DB_AT]);
                        errors++;
                    end
                end
            end
            m_tready <= calm || $urandom_range(99) >= 34;
        end
    end

    // Hang detector: counts cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("fsk_envelope_uart_deframer_unit: mismatch");
            $finish;
        end
    end

    task automatic put(int u, int l);
        sample_q.push_back(IN_W'({SAMPLE_WIDTH'(l), SAMPLE_WIDTH'(u)}));
        queued_items++;
    endtask

    task automatic add_noise(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            sample_q.push_back(IN_W'($urandom));
            queued_items++;
        end
    endtask

    // n samples of both tones at given amplitudes, sign alternating, slight droop.
    task automatic add_run(int n, int up_amp, int lo_amp);
        int k, u, l;
        for (k = 0; k < n; k++)
        begin
            u = up_amp - int'($urandom_range(up_amp / 8));
            l = lo_amp - int'($urandom_range(lo_amp / 8));
            if (k[0])
            begin
                u = -u;
                l = -l;
            end
            put(u, l);
        end
    endtask

    // Line one = upper tone (mark), line zero = lower tone, silence = invalid.
    task automatic add_bit(int kind, int n, int amp);
        if (kind == 1)
            add_run(n, amp, amp / 20);
        else if (kind == 0)
            add_run(n, amp / 20, amp);
        else
            add_run(n, 3, 3);
    endtask

    // One 8N1 frame after some mark idle; about four in ten of them are broken
    // (silent data bit, zero stop, silent stop, runt start pulse).
    task automatic add_frame(int bitlen, int amp);
        logic [7:0] payload;
        int         flaw, pos, i;
        payload = 8'($urandom);
        flaw = $urandom_range(9);
        pos = $urandom_range(7);
        add_bit(1, bitlen * $urandom_range(1, 3), amp);
        if (flaw == 3)
        begin
            add_bit(0, 1, amp);
            add_bit(1, bitlen, amp);
        end
        add_bit(0, bitlen, amp);
        for (i = 0; i < 8; i++)
        begin
            if (flaw == 0 && i == pos)
                add_bit(2, 2 * bitlen, amp);
            else
                add_bit(payload[i], bitlen, amp);
        end
        if (flaw == 1)
            add_bit(0, bitlen, amp);
        else if (flaw == 2)
            add_bit(2, 2 * bitlen, amp);
        else
            add_bit(1, bitlen, amp);
    endtask

    task automatic fill_frames(int bitlen, int n);
        int goal;
        goal = queued_items + n;
        while (queued_items < goal)
        begin
            if ($urandom_range(9) == 0)
                add_noise($urandom_range(1, 6));
            else
                add_frame(bitlen, $urandom_range(4000, 32767));
        end
    endtask

    // Writes all four registers back to back; the block must be idle.
    task automatic program_regs(logic [DECAY_W-1:0] d, logic [MIN_W-1:0] m,
                                logic [FRAC_W-1:0] f, logic [HALF_W-1:0] h);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_DECAY;
        cfg_wdata <= CFG_W'(d);
        @(posedge clk);
        cfg_addr <= REG_MIN_AMP;
        cfg_wdata <= CFG_W'(m);
        @(posedge clk);
        cfg_addr <= REG_SCHMITT;
        cfg_wdata <= CFG_W'(f);
        @(posedge clk);
        cfg_addr <= REG_HALF;
        cfg_wdata <= CFG_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_decay = d;
        cfg_min_amp = m;
        cfg_schmitt = f;
        cfg_half = h;
    endtask

    // Wait for every sent pair to come back, then let the pipe settle.
    task automatic drain();
        while (sample_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stim
        int p, h;
        cfg_decay = DECAY_RST;
        cfg_min_amp = MIN_AMP_RST;
        cfg_schmitt = SCHMITT_RST;
        cfg_half = HALF_RST;
        up_env = '0;
        lo_env = '0;
        last_line = BIT_INVALID;
        frame_timer = '0;
        bits_left = '0;
        shreg = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset defaults: full-scale codes both ways, Schmitt hold
        // while the lower tone builds up, then a start bit and back to mark.
        put(32767, 0); put(-32768, 0); put(32766, -1); put(-32767, 1);
        put(0, 32767); put(0, -32768); put(1, 32767); put(-1, -32768);
        put(0, 32767); put(0, -32768); put(0, 32767); put(0, -32768);
        put(0, 32767); put(0, -32768);
        put(21845, -21846); put(-21846, 21845);
        put(32767, 0); put(-32768, 0); put(32767, 0); put(-32768, 0);
        put(32767, 0); put(-32768, 0);
        drain();

        // Low extremes: full decay, no minimum, zero Schmitt share, shortest bit.
        program_regs('0, '0, '0, 16'd1);
        fill_frames(2, 150);
        drain();

        // High extremes: slowest decay, top minimum, top share, longest bit.
        program_regs(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_noise(40);
        add_run(20, 32767, 0);
        add_run(20, 0, 32767);
        add_noise(40);
        drain();

        // Zero half bit: each start leaves the deframer idle again.
        program_regs(decay_for(2), MIN_AMP_RST, SCHMITT_RST, '0);
        fill_frames(4, 150);
        drain();

        // Random working points; one phase runs with no idling at all.
        for (p = 0; p < 5; p++)
        begin
            h = $urandom_range(1, 6);
            calm = (p == 2);
            program_regs(decay_for(h) - DECAY_W'($urandom_range(200)),
                         MIN_W'($urandom_range(1500, 6000)),
                         FRAC_W'($urandom_range(150, 220)), HALF_W'(h));
            fill_frames(2 * h, 230);
            drain();
        end
        calm = 1'b0;

        // Fully random registers and samples.
        program_regs(DECAY_W'($urandom), MIN_W'($urandom), FRAC_W'($urandom),
                     HALF_W'($urandom_range(1, 65535)));
        add_noise(120);
        drain();

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("fsk_envelope_uart_deframer_unit: match");
        else
            $display("fsk_envelope_uart_deframer_unit: mismatch");
        $finish;
    end

endmodule
